### hdl/gef_pkg.sv
// shared constants, types and weight table function for the gaussian eddy block
`default_nettype none
package gef_pkg;

	localparam int COORD_BITS    = 16;
	localparam int AMP_BITS      = 16;
	localparam int REG_W         = 48;
	localparam int EXP_DEPTH_DEF = 256;
	localparam int DIV_STAGES    = 16;
	localparam int FRONT_STAGES  = 4;
	localparam int BACK_STAGES   = 8;
	localparam int GEF_LAT       = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

	// 1/sqrt(0.0820292) in q.16 and the reciprocal used for a divide by three
	localparam logic [17:0] INV_SQRT_Q16 = 18'd228821;
	localparam logic [15:0] RECIP3       = 16'd43691;

	typedef enum logic [2:0] {
		REG_CENTRE = 3'd0,
		REG_AXIS1  = 3'd1,
		REG_AXIS2  = 3'd2,
		REG_AXIS3  = 3'd3,
		REG_AMP    = 3'd4
	} reg_idx_t;

	// long division by shift and subtract, only evaluated when the table is built
	function automatic longint unsigned udiv64(input longint unsigned a,
			input longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int bi = 63; bi >= 0; bi--) begin
			r = {r[62:0], a[bi]};
			if (r >= b) begin
				r = r - b;
				q[bi] = 1'b1;
			end
		end
		return q;
	endfunction

	// weight entry i: round(2^46 / e^(12*i/depth)) from a truncated series in q30
	function automatic logic [16:0] weight_entry(input int unsigned i, input int unsigned depth);
		longint unsigned t;
		longint unsigned e;
		longint unsigned k;
		longint unsigned w;
		t = 64'd1 << 30;
		e = t;
		for (k = 1; k < 128 && t != 0; k++) begin
			t = udiv64(t * longint'(i), longint'(depth));
			t = udiv64(t * 64'd12, k);
			e = e + t;
		end
		w = udiv64((64'd1 << 46) + (e >> 1), e);
		return w[16:0];
	endfunction

endpackage
`default_nettype wire

### hdl/gaussian_eddy_fluctuation.sv
// top level: config registers and the gaussian eddy evaluation pipeline
// each accepted start gives a done strobe at the end of the pipeline
// throughput: one item per cycle, busy stays low; the depth is set by the
// 16-stage quotient pipeline plus 4 front and 8 back stages
// reset: arst_n clears the config registers (all zero) and all valid bits
// results cannot be stalled, done is a single-cycle strobe
`default_nettype none
module gaussian_eddy_fluctuation #(
	parameter int EXP_TABLE_DEPTH = gef_pkg::EXP_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic signed [gef_pkg::COORD_BITS-1:0] point_x,
	input  wire logic signed [gef_pkg::COORD_BITS-1:0] point_y,
	input  wire logic signed [gef_pkg::COORD_BITS-1:0] point_z,
	output logic             done,
	output logic signed [15:0] vel_x,
	output logic signed [15:0] vel_y,
	output logic signed [15:0] vel_z,
	output logic             inside_res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);
	import gef_pkg::*;

	localparam int IW = $clog2(EXP_TABLE_DEPTH);
	localparam int XW = 35 + $clog2(EXP_TABLE_DEPTH + 1);
	localparam int YW = XW - 32;
	localparam int CW = COORD_BITS;

	// config registers
	logic [REG_W-1:0] centre_q;
	logic [REG_W-1:0] axis_q [3];
	logic [REG_W-1:0] amp_q;
	logic             wr;
	reg_idx_t         ridx;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr     = psel && penable && pwrite && pready;
	assign ridx   = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q  <= '0;
			axis_q[0] <= '0;
			axis_q[1] <= '0;
			axis_q[2] <= '0;
			amp_q     <= '0;
		end else if (wr) begin
			unique case (ridx)
				REG_CENTRE: centre_q  <= pwdata[REG_W-1:0];
				REG_AXIS1:  axis_q[0] <= pwdata[REG_W-1:0];
				REG_AXIS2:  axis_q[1] <= pwdata[REG_W-1:0];
				REG_AXIS3:  axis_q[2] <= pwdata[REG_W-1:0];
				REG_AMP:    amp_q     <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (ridx)
			REG_CENTRE: prdata = {16'd0, centre_q};
			REG_AXIS1:  prdata = {16'd0, axis_q[0]};
			REG_AXIS2:  prdata = {16'd0, axis_q[1]};
			REG_AXIS3:  prdata = {16'd0, axis_q[2]};
			REG_AMP:    prdata = {16'd0, amp_q};
			default:    prdata = '0;
		endcase
	end

	// squared axis lengths, derived from config
	logic [30:0] ll_q [3][3];
	logic [31:0] n_q  [3];

	for (genvar m = 0; m < 3; m++) begin : g_len
		for (genvar j = 0; j < 3; j++) begin : g_comp
			logic signed [CW-1:0] l;
			logic signed [31:0]   sq;
			assign l  = $signed(axis_q[m][j*CW +: CW]);
			assign sq = l * l;
			always_ff @(posedge clk) ll_q[m][j] <= sq[30:0];
		end
		always_ff @(posedge clk)
			n_q[m] <= 32'(ll_q[m][0]) + 32'(ll_q[m][1]) + 32'(ll_q[m][2]);
	end

	// valid and inside flags travel with the item
	logic                   acc;
	logic [GEF_LAT-2:0]     vld_q;
	logic [GEF_LAT-5:0]     ins_q;
	logic                   in4;

	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[GEF_LAT-3:0], acc};
	end

	always_ff @(posedge clk)
		ins_q <= {ins_q[GEF_LAT-6:0], in4};

	// s1: offset from centre
	logic signed [CW:0] d_s1 [3];
	always_ff @(posedge clk) begin
		d_s1[0] <= (CW+1)'(point_x) - (CW+1)'($signed(centre_q[0*CW +: CW]));
		d_s1[1] <= (CW+1)'(point_y) - (CW+1)'($signed(centre_q[1*CW +: CW]));
		d_s1[2] <= (CW+1)'(point_z) - (CW+1)'($signed(centre_q[2*CW +: CW]));
	end

	// s2: component products, s3: dot products
	logic signed [2*CW:0]   prod_s2 [3][3];
	logic signed [2*CW+2:0] dot_s3  [3];
	for (genvar m = 0; m < 3; m++) begin : g_dot
		for (genvar j = 0; j < 3; j++) begin : g_prod
			logic signed [CW-1:0] l;
			assign l = $signed(axis_q[m][j*CW +: CW]);
			always_ff @(posedge clk) prod_s2[m][j] <= d_s1[j] * l;
		end
		always_ff @(posedge clk)
			dot_s3[m] <= (2*CW+3)'(prod_s2[m][0]) + (2*CW+3)'(prod_s2[m][1])
				+ (2*CW+3)'(prod_s2[m][2]);
	end

	// s4: magnitude and strict box test per axis
	logic [31:0] mag_s4 [3];
	logic [2:0]  in_ax;
	for (genvar m = 0; m < 3; m++) begin : g_mag
		logic [2*CW+2:0] mag;
		assign mag      = dot_s3[m][2*CW+2] ? (2*CW+3)'(-dot_s3[m]) : dot_s3[m];
		assign in_ax[m] = mag < (2*CW+3)'(n_q[m]);
		always_ff @(posedge clk) mag_s4[m] <= mag[31:0];
	end
	assign in4 = &in_ax;

	// s5..s20: per-axis ratio quotients
	logic [15:0] quo [3];
	for (genvar m = 0; m < 3; m++) begin : g_div
		gef_div u_div (
			.clk (clk),
			.num (mag_s4[m]),
			.den (n_q[m]),
			.quo (quo[m])
		);
	end

	// s21: squares, s22: sum of squares
	logic [31:0] sq_s21 [3];
	logic [33:0] sum_s22;
	for (genvar m = 0; m < 3; m++) begin : g_sq
		always_ff @(posedge clk) sq_s21[m] <= quo[m] * quo[m];
	end
	always_ff @(posedge clk)
		sum_s22 <= 34'(sq_s21[0]) + 34'(sq_s21[1]) + 34'(sq_s21[2]);

	// s23: scaled sum over 2^32, s24: divide by three and clamp
	logic [XW-1:0]    xs;
	logic [YW-1:0]    y_s23;
	logic [YW+15:0]   ty;
	logic [YW-2:0]    qd;
	logic [IW-1:0]    idx_s24;
	assign xs = XW'(sum_s22) * XW'(EXP_TABLE_DEPTH) + (XW'(3) << 31);
	always_ff @(posedge clk) y_s23 <= xs[XW-1:32];
	assign ty = (YW+16)'(y_s23) * (YW+16)'(RECIP3);
	assign qd = ty[YW+15:17];
	always_ff @(posedge clk)
		idx_s24 <= (qd > (YW-1)'(EXP_TABLE_DEPTH - 1)) ? IW'(EXP_TABLE_DEPTH - 1) : IW'(qd);

	// s25: weight lookup
	logic [16:0] wtab [EXP_TABLE_DEPTH];
	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
		assign wtab[g] = weight_entry(g, EXP_TABLE_DEPTH);
	end
	logic [16:0] w_s25;
	always_ff @(posedge clk) w_s25 <= wtab[idx_s24];

	// s26: amplitude times weight, s27: times the normalising factor
	logic [32:0] pa_s26 [3];
	logic [2:0]  neg_s26;
	logic [50:0] pb_s27 [3];
	logic [2:0]  neg_s27;
	logic signed [15:0] v_out [3];
	for (genvar j = 0; j < 3; j++) begin : g_amp
		logic signed [AMP_BITS-1:0] e;
		logic [AMP_BITS-1:0]        ae;
		logic [50:0]                rs;
		logic [16:0]                r;
		assign e  = $signed(amp_q[j*AMP_BITS +: AMP_BITS]);
		assign ae = e[AMP_BITS-1] ? AMP_BITS'(-e) : AMP_BITS'(e);
		always_ff @(posedge clk) begin
			pa_s26[j]  <= 33'(ae) * 33'(w_s25);
			neg_s26[j] <= e[AMP_BITS-1];
			pb_s27[j]  <= 51'(pa_s26[j]) * 51'(INV_SQRT_Q16);
			neg_s27[j] <= neg_s26[j];
		end
		// round half away from zero and saturate
		assign rs = pb_s27[j] + (51'd1 << 33);
		assign r  = rs[50:34];
		always_comb begin
			if (!neg_s27[j])
				v_out[j] = (r > 17'd32767) ? 16'sd32767 : $signed(r[15:0]);
			else
				v_out[j] = (r > 17'd32768) ? -16'sd32768 : $signed(16'(-r));
		end
	end

	// s28: result registers
	logic ins_now;
	assign ins_now = ins_q[GEF_LAT-5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vld_q[GEF_LAT-2];
	end

	always_ff @(posedge clk) begin
		vel_x      <= ins_now ? v_out[0] : '0;
		vel_y      <= ins_now ? v_out[1] : '0;
		vel_z      <= ins_now ? v_out[2] : '0;
		inside_res <= ins_now;
	end

endmodule
`default_nettype wire

### hdl/gef_div.sv
// pipelined restoring divider, one quotient bit per stage: floor(num * 2^16 / den) for num < den
`default_nettype none
module gef_div (
	input  wire logic        clk,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	output logic      [15:0] quo
);
	import gef_pkg::*;

	logic [31:0] rem_s [DIV_STAGES+1];
	logic [31:0] den_s [DIV_STAGES+1];
	logic [15:0] quo_s [DIV_STAGES+1];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	// one shift, compare and subtract per stage
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [32:0] tr;
		logic        ge;
		always_comb begin
			tr = {rem_s[g], 1'b0};
			ge = tr >= {1'b0, den_s[g]};
		end
		always_ff @(posedge clk) begin
			rem_s[g+1] <= ge ? 32'(tr - {1'b0, den_s[g]}) : tr[31:0];
			den_s[g+1] <= den_s[g];
			quo_s[g+1] <= {quo_s[g][14:0], ge};
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule
`default_nettype wire

### hdl/gef_chk.sv
// port-level checker for the gaussian eddy block, bound to the top level
`default_nettype none
module gef_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic signed [15:0] vel_x,
	input wire logic signed [15:0] vel_y,
	input wire logic signed [15:0] vel_z,
	input wire logic        inside_res,
	input wire logic        pready
);
	import gef_pkg::*;

	// every accepted item gives a result
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##GEF_LAT done)
		else $error("accepted item produced no result");

	// no result without an item accepted at the matching time
	a_lat_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, GEF_LAT))
		else $error("result without matching item");

	// a point outside the box gives zero velocity
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !inside_res) |-> (vel_x == 16'sd0 && vel_y == 16'sd0 && vel_z == 16'sd0))
		else $error("nonzero velocity outside the eddy");

	// config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind gaussian_eddy_fluctuation gef_chk u_gef_chk (.*);
`default_nettype wire
